// ----- src/dvbc_pkg.sv -----
`timescale 1ns / 1ps

package dvbc_pkg;

	localparam int ADDR_W      = 48;
	localparam int LEN_W       = 24;
	localparam int BITS_W      = 64;
	localparam int MSG_W       = 3;
	localparam int VIEWS_W     = 7;
	localparam int MM_W        = 4;
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [0:0] REG_MAX_MESSAGES = 1'b0;

	typedef enum logic [1:0] {
		OSEL_ADD   = 2'd0,
		OSEL_ENTRY = 2'd1,
		OSEL_EMPTY = 2'd2
	} osel_t;

	typedef struct packed {
		logic  start_add;
		logic  start_drain;
		logic  piece;
		logic  search;
		logic  merge;
		logic  append;
		logic  load_out;
		osel_t osel;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic full;
		logic rem_zero;
		logic match;
		logic miss;
		logic last_entry;
		logic out_free;
	} dp_sts_t;

endpackage

// ----- src/dvbc_ifs.sv -----
`timescale 1ns / 1ps

interface dvbc_in_if;
	logic                             valid;
	logic                             ready;
	logic                             cmd;
	logic [dvbc_pkg::ADDR_W-1:0]      start_address;
	logic [dvbc_pkg::LEN_W-1:0]       region_length;

	modport source (output valid, cmd, start_address, region_length, input ready);
	modport sink   (input valid, cmd, start_address, region_length, output ready);
endinterface

interface dvbc_out_if;
	logic                             valid;
	logic                             ready;
	logic [dvbc_pkg::ADDR_W-1:0]      view_address;
	logic [dvbc_pkg::BITS_W-1:0]      dirty_bits;
	logic [dvbc_pkg::MSG_W-1:0]       message_index;
	logic                             entry_valid;
	logic                             last;
	logic                             region_done;
	logic [dvbc_pkg::VIEWS_W-1:0]     views_recorded;

	modport source (output valid, view_address, dirty_bits, message_index, entry_valid,
		last, region_done, views_recorded, input ready);
	modport sink   (input valid, view_address, dirty_bits, message_index, entry_valid,
		last, region_done, views_recorded, output ready);
endinterface

// ----- src/dvbc_ram.sv -----
`timescale 1ns / 1ps

module dvbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/dvbc_ctrl.sv -----
`timescale 1ns / 1ps

module dvbc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_cmd,
	output logic               in_ready,
	input  dvbc_pkg::dp_sts_t  sts,
	output dvbc_pkg::dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_PIECE    = 7'b0000010,
		ST_SEARCH   = 7'b0000100,
		ST_RESULT   = 7'b0001000,
		ST_EMPTY    = 7'b0010000,
		ST_DRAIN_RD = 7'b0100000,
		ST_DRAIN_WR = 7'b1000000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.osel  = dvbc_pkg::OSEL_ADD;
		state_nxt = state_q;
		in_ready  = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!in_cmd) begin
						cmd.start_add = 1'b1;
						state_nxt     = ST_PIECE;
					end else if (sts.cnt_zero) begin
						state_nxt = ST_EMPTY;
					end else begin
						cmd.start_drain = 1'b1;
						state_nxt       = ST_DRAIN_RD;
					end
				end
			end
			ST_PIECE: begin
				if (sts.rem_zero || sts.full) begin
					state_nxt = ST_RESULT;
				end else begin
					cmd.piece = 1'b1;
					state_nxt = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (sts.match) begin
					cmd.merge = 1'b1;
					state_nxt = ST_PIECE;
				end else if (sts.miss) begin
					cmd.append = 1'b1;
					state_nxt  = ST_PIECE;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.osel     = dvbc_pkg::OSEL_ADD;
					state_nxt    = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.osel     = dvbc_pkg::OSEL_EMPTY;
					state_nxt    = ST_IDLE;
				end
			end
			ST_DRAIN_RD: begin
				state_nxt = ST_DRAIN_WR;
			end
			ST_DRAIN_WR: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.osel     = dvbc_pkg::OSEL_ENTRY;
					state_nxt    = sts.last_entry ? ST_IDLE : ST_DRAIN_RD;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/dvbc_datapath.sv -----
`timescale 1ns / 1ps

module dvbc_datapath #(
	parameter int PAGE_BITS           = 12,
	parameter int PAGES_PER_VIEW      = 64,
	parameter int ENTRIES_PER_MESSAGE = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dvbc_pkg::dp_cmd_t                 cmd,
	output dvbc_pkg::dp_sts_t                 sts,
	input  logic [dvbc_pkg::ADDR_W-1:0]       start_address,
	input  logic [dvbc_pkg::LEN_W-1:0]        region_length,
	input  logic [dvbc_pkg::MM_W-1:0]         max_messages,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [dvbc_pkg::ADDR_W-1:0]       view_address,
	output logic [dvbc_pkg::BITS_W-1:0]       dirty_bits,
	output logic [dvbc_pkg::MSG_W-1:0]        message_index,
	output logic                              entry_valid,
	output logic                              last,
	output logic                              region_done,
	output logic [dvbc_pkg::VIEWS_W-1:0]      views_recorded
);

	localparam int ADDR_W = dvbc_pkg::ADDR_W;
	localparam int LEN_W  = dvbc_pkg::LEN_W;
	localparam int IDX_W  = dvbc_pkg::IDX_W;
	localparam int CNT_W  = dvbc_pkg::CNT_W;
	localparam int PV_W   = $clog2(PAGES_PER_VIEW);
	localparam int VB     = PAGE_BITS + PV_W;
	localparam int TAG_W  = ADDR_W - VB;
	localparam int EP_W   = PV_W + 1;
	localparam int SUB_W  = $clog2(ENTRIES_PER_MESSAGE + 1);
	localparam int CAP_PW = dvbc_pkg::MM_W + SUB_W;
	localparam logic [VB:0] VIEW_BYTES = (VB+1)'(1) << VB;
	localparam logic [VB:0] PAGE_MASK  = ((VB+1)'(1) << PAGE_BITS) - (VB+1)'(1);

	// piece registers
	logic [ADDR_W-1:0]          cur_q;
	logic [LEN_W-1:0]           rem_q;
	logic [dvbc_pkg::VIEWS_W-1:0] views_q;
	logic [TAG_W-1:0]           tag_q;
	logic [PAGES_PER_VIEW-1:0]  bits_q;
	logic [VB:0]                len_q;

	// table and scan control
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           idx_q;
	logic                       chk_vld_s1;
	logic [IDX_W-1:0]           chk_idx_s1;
	logic [dvbc_pkg::MSG_W-1:0] msg_q;
	logic [SUB_W-1:0]           sub_q;

	logic                       v_we, m_we;
	logic [IDX_W-1:0]           m_waddr;
	logic [PAGES_PER_VIEW-1:0]  m_wdata;
	logic [TAG_W-1:0]           v_rdata;
	logic [PAGES_PER_VIEW-1:0]  m_rdata;

	logic [VB-1:0]              off;
	logic [VB:0]                room, end_sum, end_rnd, len_c;
	logic                       fits;
	logic [EP_W-1:0]            ep;
	logic [PV_W-1:0]            sp;
	logic [PAGES_PER_VIEW-1:0]  bits_c;
	logic [CAP_PW-1:0]          cap_prod;
	logic [CNT_W-1:0]           cap;
	logic                       issue;
	logic                       last_entry;

	// piece of the region inside the current view
	always_comb begin
		off     = cur_q[VB-1:0];
		room    = VIEW_BYTES - {1'b0, off};
		fits    = rem_q < LEN_W'(room);
		end_sum = {1'b0, off} + rem_q[VB:0];
		end_rnd = end_sum + PAGE_MASK;
		sp      = off[VB-1:PAGE_BITS];
		if (fits) begin
			len_c = rem_q[VB:0];
			ep    = end_rnd[VB:PAGE_BITS];
		end else begin
			len_c = room;
			ep    = EP_W'(PAGES_PER_VIEW);
		end
		for (int j = 0; j < PAGES_PER_VIEW; j++) begin
			bits_c[j] = (EP_W'(j) < ep) && !(PV_W'(j) < sp);
		end
	end

	always_comb begin
		cap_prod = CAP_PW'(max_messages) * CAP_PW'(ENTRIES_PER_MESSAGE);
		cap      = (cap_prod > CAP_PW'(dvbc_pkg::TABLE_DEPTH)) ?
			CNT_W'(dvbc_pkg::TABLE_DEPTH) : CNT_W'(cap_prod);
	end

	assign issue      = idx_q < cnt_q;
	assign last_entry = (idx_q == (cnt_q - CNT_W'(1)));

	always_comb begin
		sts.cnt_zero   = (cnt_q == '0);
		sts.full       = (cnt_q >= cap);
		sts.rem_zero   = (rem_q == '0);
		sts.match      = chk_vld_s1 && (v_rdata == tag_q);
		sts.miss       = !chk_vld_s1 && !issue;
		sts.last_entry = last_entry;
		sts.out_free   = !out_valid || out_ready;
	end

	assign v_we    = cmd.append;
	assign m_we    = cmd.append || cmd.merge;
	assign m_waddr = cmd.merge ? chk_idx_s1 : cnt_q[IDX_W-1:0];
	assign m_wdata = cmd.merge ? (m_rdata | bits_q) : bits_q;

	dvbc_ram #(
		.WIDTH (TAG_W),
		.DEPTH (dvbc_pkg::TABLE_DEPTH)
	) u_view_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (tag_q),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (v_rdata)
	);

	dvbc_ram #(
		.WIDTH (PAGES_PER_VIEW),
		.DEPTH (dvbc_pkg::TABLE_DEPTH)
	) u_mask_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (m_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.start_add) begin
			cur_q   <= start_address;
			rem_q   <= region_length;
			views_q <= '0;
		end
		if (cmd.piece) begin
			tag_q  <= cur_q[ADDR_W-1:VB];
			bits_q <= bits_c;
			len_q  <= len_c;
		end
		if (cmd.search) begin
			chk_idx_s1 <= idx_q[IDX_W-1:0];
		end
		if (cmd.merge || cmd.append) begin
			cur_q <= cur_q + ADDR_W'(len_q);
			rem_q <= rem_q - LEN_W'(len_q);
			if (views_q != '1) begin
				views_q <= views_q + dvbc_pkg::VIEWS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			idx_q      <= '0;
			chk_vld_s1 <= 1'b0;
			msg_q      <= '0;
			sub_q      <= '0;
		end else begin
			if (cmd.piece) begin
				idx_q      <= '0;
				chk_vld_s1 <= 1'b0;
			end
			// one table read issued and one compared per cycle
			if (cmd.search) begin
				idx_q      <= idx_q + CNT_W'(issue);
				chk_vld_s1 <= issue;
			end
			if (cmd.append) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.start_drain) begin
				idx_q <= '0;
				msg_q <= '0;
				sub_q <= '0;
			end
			if (cmd.load_out && (cmd.osel == dvbc_pkg::OSEL_ENTRY)) begin
				if (last_entry) begin
					cnt_q <= '0;
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (sub_q == SUB_W'(ENTRIES_PER_MESSAGE - 1)) begin
					sub_q <= '0;
					msg_q <= msg_q + dvbc_pkg::MSG_W'(1);
				end else begin
					sub_q <= sub_q + SUB_W'(1);
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (cmd.osel)
				dvbc_pkg::OSEL_ENTRY: begin
					view_address   <= {v_rdata, {VB{1'b0}}};
					dirty_bits     <= dvbc_pkg::BITS_W'(m_rdata);
					message_index  <= msg_q;
					entry_valid    <= 1'b1;
					last           <= last_entry;
					region_done    <= 1'b0;
					views_recorded <= '0;
				end
				dvbc_pkg::OSEL_ADD: begin
					view_address   <= '0;
					dirty_bits     <= '0;
					message_index  <= '0;
					entry_valid    <= 1'b0;
					last           <= 1'b1;
					region_done    <= (rem_q == '0);
					views_recorded <= views_q;
				end
				default: begin
					view_address   <= '0;
					dirty_bits     <= '0;
					message_index  <= '0;
					entry_valid    <= 1'b0;
					last           <= 1'b1;
					region_done    <= 1'b0;
					views_recorded <= '0;
				end
			endcase
		end
	end

endmodule

// ----- src/dirty_view_bitmap_coalescer.sv -----
`timescale 1ns / 1ps
// add: each view piece is searched in the table, then merged or appended
// (one entry compared per cycle, the table memory reads registered)
// drain: each entry is read, then emitted; an empty drain emits one empty word
// one item at a time; a finished word waits in the output register while the next
// item is accepted, and a stalled output register holds the controller
// reset clears control, entry count and max_messages (to 8); table memory is not cleared

module dirty_view_bitmap_coalescer #(
	parameter int PAGE_BITS           = 12,
	parameter int PAGES_PER_VIEW      = 64,
	parameter int ENTRIES_PER_MESSAGE = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dvbc_pkg::PADDR_W-1:0]   paddr,
	input  logic [dvbc_pkg::PDATA_W-1:0]   pwdata,
	output logic [dvbc_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	dvbc_in_if.sink                        in_ch,
	dvbc_out_if.source                     out_ch
);

	logic [dvbc_pkg::MM_W-1:0] max_messages_q;
	logic                      sel_mm;
	dvbc_pkg::dp_cmd_t         cmd;
	dvbc_pkg::dp_sts_t         sts;

	assign pready = 1'b1;
	assign sel_mm = (paddr[2] == dvbc_pkg::REG_MAX_MESSAGES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_messages_q <= dvbc_pkg::MM_W'(8);
		end else if (psel && penable && pwrite && pready && sel_mm) begin
			max_messages_q <= pwdata[dvbc_pkg::MM_W-1:0];
		end
	end

	assign prdata = sel_mm ? dvbc_pkg::PDATA_W'(max_messages_q) : '0;

	dvbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_cmd   (in_ch.cmd),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dvbc_datapath #(
		.PAGE_BITS           (PAGE_BITS),
		.PAGES_PER_VIEW      (PAGES_PER_VIEW),
		.ENTRIES_PER_MESSAGE (ENTRIES_PER_MESSAGE)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.start_address  (in_ch.start_address),
		.region_length  (in_ch.region_length),
		.max_messages   (max_messages_q),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.view_address   (out_ch.view_address),
		.dirty_bits     (out_ch.dirty_bits),
		.message_index  (out_ch.message_index),
		.entry_valid    (out_ch.entry_valid),
		.last           (out_ch.last),
		.region_done    (out_ch.region_done),
		.views_recorded (out_ch.views_recorded)
	);

endmodule
